// File: rtl/core/acc_pkg.sv
`default_nettype none

package acc_pkg;

   localparam int MAX_CLASSES  = 21;
   localparam int SCORE_WIDTH  = 16;
   localparam int CLASS_WIDTH  = 5;
   localparam int COUNT_WIDTH  = 5;
   localparam int COLOR_WIDTH  = 8;
   localparam int ADDR_WIDTH   = 3;
   localparam int DATA_WIDTH   = 32;

   localparam logic [0:0] REG_CLASS_COUNT     = 1'b0;
   localparam logic [0:0] REG_START_FROM_ZERO = 1'b1;

   localparam logic [COUNT_WIDTH-1:0] CLASS_COUNT_RESET = COUNT_WIDTH'(21);

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] class_count;
      logic                   start_from_zero;
   } cfg_type;

   typedef struct packed {
      logic [CLASS_WIDTH-1:0] class_index;
      logic [COLOR_WIDTH-1:0] blue;
      logic [COLOR_WIDTH-1:0] green;
      logic [COLOR_WIDTH-1:0] red;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/acc_argmax.sv
`default_nettype none

module acc_argmax (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  step,
   input  wire logic signed [acc_pkg::SCORE_WIDTH-1:0] score,
   input  wire acc_pkg::cfg_type                      cfg,
   output      logic                                  last,
   output      acc_pkg::result_type                   result
);

   logic signed [acc_pkg::SCORE_WIDTH-1:0] best_score_ff;
   logic signed [acc_pkg::SCORE_WIDTH-1:0] best_score_in;
   logic [acc_pkg::CLASS_WIDTH-1:0]        best_class_ff;
   logic [acc_pkg::CLASS_WIDTH-1:0]        best_class_in;
   logic [acc_pkg::COUNT_WIDTH-1:0]        channel_ff;
   logic [acc_pkg::COUNT_WIDTH-1:0]        channel_in;
   logic [acc_pkg::COUNT_WIDTH:0]          limit;

   function automatic logic [3*acc_pkg::COLOR_WIDTH-1:0] palette_bgr(
      input logic [acc_pkg::CLASS_WIDTH-1:0] c
   );
      logic [3*acc_pkg::COLOR_WIDTH-1:0] bgr;
      case (c)
         5'd0:    bgr = {8'd0,   8'd0,   8'd0};
         5'd1:    bgr = {8'd0,   8'd0,   8'd128};
         5'd2:    bgr = {8'd0,   8'd128, 8'd0};
         5'd3:    bgr = {8'd0,   8'd128, 8'd128};
         5'd4:    bgr = {8'd128, 8'd0,   8'd0};
         5'd5:    bgr = {8'd128, 8'd0,   8'd128};
         5'd6:    bgr = {8'd128, 8'd128, 8'd0};
         5'd7:    bgr = {8'd128, 8'd128, 8'd128};
         5'd8:    bgr = {8'd0,   8'd0,   8'd64};
         5'd9:    bgr = {8'd0,   8'd0,   8'd192};
         5'd10:   bgr = {8'd0,   8'd192, 8'd64};
         5'd11:   bgr = {8'd0,   8'd128, 8'd192};
         5'd12:   bgr = {8'd128, 8'd0,   8'd64};
         5'd13:   bgr = {8'd128, 8'd0,   8'd192};
         5'd14:   bgr = {8'd128, 8'd128, 8'd64};
         5'd15:   bgr = {8'd128, 8'd128, 8'd192};
         5'd16:   bgr = {8'd0,   8'd64,  8'd0};
         5'd17:   bgr = {8'd0,   8'd64,  8'd128};
         5'd18:   bgr = {8'd0,   8'd192, 8'd0};
         5'd19:   bgr = {8'd0,   8'd192, 8'd128};
         5'd20:   bgr = {8'd128, 8'd64,  8'd0};
         default: bgr = '0;
      endcase
      return bgr;
   endfunction

   always_comb begin
      if (cfg.class_count == '0) begin
         limit = (acc_pkg::COUNT_WIDTH+1)'(1);
      end else if ({1'b0, cfg.class_count} > (acc_pkg::COUNT_WIDTH+1)'(acc_pkg::MAX_CLASSES))
         begin
         limit = (acc_pkg::COUNT_WIDTH+1)'(acc_pkg::MAX_CLASSES);
      end else begin
         limit = {1'b0, cfg.class_count};
      end
   end

   assign last = ({1'b0, channel_ff} + (acc_pkg::COUNT_WIDTH+1)'(1)) >= limit;

   always_comb begin
      best_score_in = best_score_ff;
      best_class_in = best_class_ff;
      if (channel_ff == '0) begin
         best_class_in = '0;
         if (cfg.start_from_zero && !(score > 0)) begin
            best_score_in = '0;
         end else begin
            best_score_in = score;
         end
      end else if (score > best_score_ff) begin
         best_score_in = score;
         best_class_in = acc_pkg::CLASS_WIDTH'(channel_ff);
      end
      channel_in = last ? '0 : channel_ff + acc_pkg::COUNT_WIDTH'(1);
   end

   always_comb begin
      result.class_index = best_class_in;
      {result.blue, result.green, result.red} = palette_bgr(best_class_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= '0;
         best_class_ff <= '0;
         channel_ff    <= '0;
      end else if (step) begin
         best_score_ff <= best_score_in;
         best_class_ff <= best_class_in;
         channel_ff    <= channel_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/argmax_class_colorizer_unit.sv
`default_nettype none
// Output: the result beat is registered and leaves in the cycle after the last score of a pixel is taken.
// Throughput: one score per cycle; a last score waits only while an earlier result
// beat is still held in the output register and stalled.
// Reset: synchronous, active high; clears the running maximum, channel count and
// output valid, and returns class_count to 21 and start_from_zero to 0.
module argmax_class_colorizer_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic signed [acc_pkg::SCORE_WIDTH-1:0] req_score,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic [acc_pkg::CLASS_WIDTH-1:0]       rsp_class_index,
   output      logic [acc_pkg::COLOR_WIDTH-1:0]       rsp_blue,
   output      logic [acc_pkg::COLOR_WIDTH-1:0]       rsp_green,
   output      logic [acc_pkg::COLOR_WIDTH-1:0]       rsp_red,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [acc_pkg::ADDR_WIDTH-1:0]        paddr,
   input  wire logic [acc_pkg::DATA_WIDTH-1:0]        pwdata,
   output      logic [acc_pkg::DATA_WIDTH-1:0]        prdata,
   output      logic                                  pready
);

   acc_pkg::cfg_type    cfg_ff;
   acc_pkg::result_type result;
   acc_pkg::result_type rsp_ff;
   logic                rsp_valid_ff;
   logic                last;
   logic                accept;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[2])
         acc_pkg::REG_CLASS_COUNT:     prdata = acc_pkg::DATA_WIDTH'(cfg_ff.class_count);
         acc_pkg::REG_START_FROM_ZERO: prdata = acc_pkg::DATA_WIDTH'(cfg_ff.start_from_zero);
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.class_count     <= acc_pkg::CLASS_COUNT_RESET;
         cfg_ff.start_from_zero <= 1'b0;
      end else if (csr_write) begin
         case (paddr[2])
            acc_pkg::REG_CLASS_COUNT:
               cfg_ff.class_count <= pwdata[acc_pkg::COUNT_WIDTH-1:0];
            acc_pkg::REG_START_FROM_ZERO:
               cfg_ff.start_from_zero <= pwdata[0];
            default: ;
         endcase
      end
   end

   // hold a last score while a stalled result beat occupies the output
   assign req_stall = last && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   acc_argmax u_argmax (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .score  (req_score),
      .cfg    (cfg_ff),
      .last   (last),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = rsp_ff.class_index;
   assign rsp_blue        = rsp_ff.blue;
   assign rsp_green       = rsp_ff.green;
   assign rsp_red         = rsp_ff.red;

`ifndef SYNTH
   a_last_loads_output: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> rsp_valid_ff)
      else $error("last score did not produce a result beat");

   a_mid_pixel_no_beat: assert property (@(posedge clock) disable iff (reset)
      (accept && !last && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result beat appeared mid pixel");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result beat was lost or overwritten");

   a_class_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.class_index < acc_pkg::CLASS_WIDTH'(acc_pkg::MAX_CLASSES)))
      else $error("winning class out of range");
`endif

endmodule

`default_nettype wire
